@@ rtl/core/mqttrx_pkg.sv @@
`default_nettype none

package mqttrx_pkg;

	localparam int unsigned MAX_LENGTH_BYTES = 4;

	localparam int unsigned LEN_W   = 28;
	localparam int unsigned TOPIC_W = 16;
	localparam int unsigned COUNT_W = 32;
	localparam int unsigned CODE_W  = 8;
	localparam int unsigned LCNT_W  = 3;
	localparam int unsigned NEED_W  = 18;

	localparam logic [3:0] PT_CONNACK  = 4'd2;
	localparam logic [3:0] PT_PUBLISH  = 4'd3;
	localparam logic [3:0] PT_SUBACK   = 4'd9;
	localparam logic [3:0] PT_PINGRESP = 4'd13;

	localparam logic [7:0] LEN_DATA_MASK  = 8'h7F;
	localparam logic [7:0] LEN_CONT_MASK  = 8'h80;
	localparam logic [7:0] SUBACK_FAILURE = 8'h80;

	typedef enum logic [1:0] {
		PH_HEADER,
		PH_LENGTH,
		PH_BODY
	} phase_t;

	typedef enum logic [3:0] {
		ROLE_HEADER    = 4'd0,
		ROLE_LENGTH    = 4'd1,
		ROLE_TOPIC_LEN = 4'd2,
		ROLE_TOPIC     = 4'd3,
		ROLE_PACKET_ID = 4'd4,
		ROLE_PAYLOAD   = 4'd5,
		ROLE_CONNACK   = 4'd6,
		ROLE_SUBACK    = 4'd7,
		ROLE_OTHER     = 4'd8,
		ROLE_DISCARD   = 4'd9
	} role_t;

	typedef enum logic [3:0] {
		EV_NONE            = 4'd0,
		EV_CONNACK_OK      = 4'd1,
		EV_CONNACK_REJECT  = 4'd2,
		EV_CONNACK_SHORT   = 4'd3,
		EV_PUBLISH         = 4'd4,
		EV_PUBLISH_BAD     = 4'd5,
		EV_SUBACK_OK       = 4'd6,
		EV_SUBACK_REJECT   = 4'd7,
		EV_SUBACK_SHORT    = 4'd8,
		EV_PINGRESP        = 4'd9,
		EV_UNKNOWN         = 4'd10,
		EV_PROTOCOL_ERROR  = 4'd11
	} event_t;

	typedef struct packed {
		role_t                byte_role;
		logic [3:0]           packet_type;
		logic [3:0]           packet_flags;
		logic [LEN_W-1:0]     remaining_length;
		logic                 packet_done;
		event_t               event_code;
		logic [CODE_W-1:0]    return_code;
		logic [TOPIC_W-1:0]   topic_length;
		logic [COUNT_W-1:0]   publish_count;
	} result_t;

endpackage

`default_nettype wire

@@ rtl/core/mqttrx_if.sv @@
`default_nettype none

interface mqttrx_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;
	logic       flush;

	modport source (output valid, output rx_byte, output flush, input ready);
	modport sink (input valid, input rx_byte, input flush, output ready);
endinterface

interface mqttrx_out_if;
	logic                                   valid;
	logic                                   ready;
	mqttrx_pkg::role_t                      byte_role;
	logic [3:0]                             packet_type;
	logic [3:0]                             packet_flags;
	logic [mqttrx_pkg::LEN_W-1:0]           remaining_length;
	logic                                   packet_done;
	mqttrx_pkg::event_t                     event_code;
	logic [mqttrx_pkg::CODE_W-1:0]          return_code;
	logic [mqttrx_pkg::TOPIC_W-1:0]         topic_length;
	logic [mqttrx_pkg::COUNT_W-1:0]         publish_count;

	modport source (output valid, output byte_role, output packet_type, output packet_flags,
		output remaining_length, output packet_done, output event_code, output return_code,
		output topic_length, output publish_count, input ready);
	modport sink (input valid, input byte_role, input packet_type, input packet_flags,
		input remaining_length, input packet_done, input event_code, input return_code,
		input topic_length, input publish_count, output ready);
endinterface

`default_nettype wire

@@ rtl/core/mqtt_rx_packet_deframer.sv @@
// The result of an accepted byte is captured in the output register when the byte is accepted.
// Throughput: one byte per cycle while parsed.ready does not hold the output; the
// parser state (phase, length, body position) advances with each accepted byte, and
// the output register takes a new byte in the cycle its previous result is sent out.
// Reset: arst_n clears the parser to awaiting a header byte, zeroes the
// publish counter and empties the output register.
`default_nettype none

module mqtt_rx_packet_deframer (
	input  wire logic      clk,
	input  wire logic      arst_n,
	mqttrx_in_if.sink      rx,
	mqttrx_out_if.source   parsed
);

	mqttrx_pkg::phase_t                     phase_q, phase_d;
	logic [3:0]                             type_q, type_d;
	logic [3:0]                             flags_q, flags_d;
	logic [mqttrx_pkg::LEN_W-1:0]           accum_q, accum_d;
	logic [mqttrx_pkg::LCNT_W-1:0]          lcnt_q, lcnt_d;
	logic [mqttrx_pkg::LEN_W-1:0]           pos_q, pos_d;
	logic [mqttrx_pkg::TOPIC_W-1:0]         topic_q, topic_d;
	logic [mqttrx_pkg::CODE_W-1:0]          code_q, code_d;
	logic [mqttrx_pkg::COUNT_W-1:0]         pub_cnt_q, pub_cnt_d;

	mqttrx_pkg::role_t                      role_d;
	mqttrx_pkg::event_t                     ev_d;
	logic                                   done_d;
	logic                                   clear_after;

	logic [1:0]                             len_grp;
	logic [mqttrx_pkg::LCNT_W-1:0]          lcnt_inc;
	logic [mqttrx_pkg::LEN_W-1:0]           len_add;
	logic [mqttrx_pkg::LEN_W-1:0]           accum_sum;
	logic [mqttrx_pkg::LEN_W-1:0]           pos_inc;
	logic [mqttrx_pkg::NEED_W-1:0]          topic_end;
	logic [mqttrx_pkg::NEED_W-1:0]          id_end;

	mqttrx_pkg::result_t                    res_d, res_q;
	logic                                   out_valid_q;
	logic                                   acc;

	function automatic mqttrx_pkg::event_t judge(
		input logic [3:0]                       ptype,
		input logic [3:0]                       pflags,
		input logic [mqttrx_pkg::LEN_W-1:0]     n,
		input logic [mqttrx_pkg::CODE_W-1:0]    code,
		input logic [mqttrx_pkg::TOPIC_W-1:0]   tlen
	);
		logic [mqttrx_pkg::NEED_W-1:0] need;
		mqttrx_pkg::event_t            ev;
		need = mqttrx_pkg::NEED_W'(2) + mqttrx_pkg::NEED_W'(tlen)
			+ ((pflags[2:1] != 2'b00) ? mqttrx_pkg::NEED_W'(2) : '0);
		unique case (ptype)
			mqttrx_pkg::PT_CONNACK: begin
				if (n < mqttrx_pkg::LEN_W'(2))
					ev = mqttrx_pkg::EV_CONNACK_SHORT;
				else if (code == '0)
					ev = mqttrx_pkg::EV_CONNACK_OK;
				else
					ev = mqttrx_pkg::EV_CONNACK_REJECT;
			end
			mqttrx_pkg::PT_PUBLISH: begin
				if (n < mqttrx_pkg::LEN_W'(need))
					ev = mqttrx_pkg::EV_PUBLISH_BAD;
				else
					ev = mqttrx_pkg::EV_PUBLISH;
			end
			mqttrx_pkg::PT_SUBACK: begin
				if (n < mqttrx_pkg::LEN_W'(3))
					ev = mqttrx_pkg::EV_SUBACK_SHORT;
				else if (code == mqttrx_pkg::SUBACK_FAILURE)
					ev = mqttrx_pkg::EV_SUBACK_REJECT;
				else
					ev = mqttrx_pkg::EV_SUBACK_OK;
			end
			mqttrx_pkg::PT_PINGRESP: ev = mqttrx_pkg::EV_PINGRESP;
			default:                 ev = mqttrx_pkg::EV_UNKNOWN;
		endcase
		return ev;
	endfunction

	assign rx.ready = !out_valid_q || parsed.ready;
	assign acc      = rx.valid && rx.ready;

	// Length groups past the fourth land in the top group, as the count saturates.
	assign len_grp   = (lcnt_q > mqttrx_pkg::LCNT_W'(3)) ? 2'd3 : lcnt_q[1:0];
	assign lcnt_inc  = mqttrx_pkg::LCNT_W'(len_grp) + mqttrx_pkg::LCNT_W'(1);
	assign len_add   = mqttrx_pkg::LEN_W'(rx.rx_byte & mqttrx_pkg::LEN_DATA_MASK)
		<< (5'd7 * 5'(len_grp));
	assign accum_sum = accum_q + len_add;
	assign pos_inc   = pos_q + mqttrx_pkg::LEN_W'(1);
	assign topic_end = mqttrx_pkg::NEED_W'(2) + mqttrx_pkg::NEED_W'(topic_q);
	assign id_end    = topic_end + ((flags_q[2:1] != 2'b00) ? mqttrx_pkg::NEED_W'(2) : '0);

	always_comb begin
		phase_d     = phase_q;
		type_d      = type_q;
		flags_d     = flags_q;
		accum_d     = accum_q;
		lcnt_d      = lcnt_q;
		pos_d       = pos_q;
		topic_d     = topic_q;
		code_d      = code_q;
		role_d      = mqttrx_pkg::ROLE_HEADER;
		ev_d        = mqttrx_pkg::EV_NONE;
		done_d      = 1'b0;
		clear_after = 1'b0;

		if (rx.flush) begin
			phase_d = mqttrx_pkg::PH_HEADER;
			type_d  = '0;
			flags_d = '0;
			accum_d = '0;
			lcnt_d  = '0;
			pos_d   = '0;
			topic_d = '0;
			code_d  = '0;
			role_d  = mqttrx_pkg::ROLE_DISCARD;
		end else begin
			unique case (phase_q)
				mqttrx_pkg::PH_HEADER: begin
					phase_d = mqttrx_pkg::PH_LENGTH;
					type_d  = rx.rx_byte[7:4];
					flags_d = rx.rx_byte[3:0];
					accum_d = '0;
					lcnt_d  = '0;
					pos_d   = '0;
					topic_d = '0;
					code_d  = '0;
					role_d  = mqttrx_pkg::ROLE_HEADER;
				end
				mqttrx_pkg::PH_LENGTH: begin
					role_d  = mqttrx_pkg::ROLE_LENGTH;
					accum_d = accum_sum;
					lcnt_d  = lcnt_inc;
					if ((rx.rx_byte & mqttrx_pkg::LEN_CONT_MASK) != '0) begin
						if (lcnt_inc >= mqttrx_pkg::LCNT_W'(mqttrx_pkg::MAX_LENGTH_BYTES)) begin
							done_d      = 1'b1;
							ev_d        = mqttrx_pkg::EV_PROTOCOL_ERROR;
							clear_after = 1'b1;
						end
					end else if (accum_sum == '0) begin
						done_d  = 1'b1;
						ev_d    = judge(type_q, flags_q, accum_sum, code_q, topic_q);
						phase_d = mqttrx_pkg::PH_HEADER;
					end else begin
						pos_d   = '0;
						phase_d = mqttrx_pkg::PH_BODY;
					end
				end
				mqttrx_pkg::PH_BODY: begin
					pos_d = pos_inc;
					unique case (type_q)
						mqttrx_pkg::PT_CONNACK: begin
							if (pos_q == mqttrx_pkg::LEN_W'(1))
								code_d = rx.rx_byte;
							role_d = mqttrx_pkg::ROLE_CONNACK;
						end
						mqttrx_pkg::PT_SUBACK: begin
							if (pos_q == mqttrx_pkg::LEN_W'(2))
								code_d = rx.rx_byte;
							role_d = mqttrx_pkg::ROLE_SUBACK;
						end
						mqttrx_pkg::PT_PUBLISH: begin
							priority if (pos_q == '0) begin
								topic_d = {rx.rx_byte, 8'h00};
								role_d  = mqttrx_pkg::ROLE_TOPIC_LEN;
							end else if (pos_q == mqttrx_pkg::LEN_W'(1)) begin
								topic_d = {topic_q[15:8], rx.rx_byte};
								role_d  = mqttrx_pkg::ROLE_TOPIC_LEN;
							end else if (pos_q < mqttrx_pkg::LEN_W'(topic_end)) begin
								role_d = mqttrx_pkg::ROLE_TOPIC;
							end else if (pos_q < mqttrx_pkg::LEN_W'(id_end)) begin
								role_d = mqttrx_pkg::ROLE_PACKET_ID;
							end else begin
								role_d = mqttrx_pkg::ROLE_PAYLOAD;
							end
						end
						default: role_d = mqttrx_pkg::ROLE_OTHER;
					endcase
					if (pos_inc >= accum_q) begin
						done_d  = 1'b1;
						ev_d    = judge(type_q, flags_q, accum_q, code_d, topic_d);
						phase_d = mqttrx_pkg::PH_HEADER;
					end
				end
				default: phase_d = mqttrx_pkg::PH_HEADER;
			endcase
		end

		pub_cnt_d = (ev_d == mqttrx_pkg::EV_PUBLISH)
			? pub_cnt_q + mqttrx_pkg::COUNT_W'(1) : pub_cnt_q;

		res_d.byte_role        = role_d;
		res_d.packet_type      = type_d;
		res_d.packet_flags     = flags_d;
		res_d.remaining_length = accum_d;
		res_d.packet_done      = done_d;
		res_d.event_code       = ev_d;
		res_d.return_code      = code_d;
		res_d.topic_length     = topic_d;
		res_d.publish_count    = pub_cnt_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= mqttrx_pkg::PH_HEADER;
			type_q    <= '0;
			flags_q   <= '0;
			accum_q   <= '0;
			lcnt_q    <= '0;
			pos_q     <= '0;
			topic_q   <= '0;
			code_q    <= '0;
			pub_cnt_q <= '0;
		end else if (acc) begin
			pub_cnt_q <= pub_cnt_d;
			if (clear_after) begin
				phase_q <= mqttrx_pkg::PH_HEADER;
				type_q  <= '0;
				flags_q <= '0;
				accum_q <= '0;
				lcnt_q  <= '0;
				pos_q   <= '0;
				topic_q <= '0;
				code_q  <= '0;
			end else begin
				phase_q <= phase_d;
				type_q  <= type_d;
				flags_q <= flags_d;
				accum_q <= accum_d;
				lcnt_q  <= lcnt_d;
				pos_q   <= pos_d;
				topic_q <= topic_d;
				code_q  <= code_d;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (acc) begin
			out_valid_q <= 1'b1;
		end else if (parsed.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			res_q <= res_d;
		end
	end

	assign parsed.valid            = out_valid_q;
	assign parsed.byte_role        = res_q.byte_role;
	assign parsed.packet_type      = res_q.packet_type;
	assign parsed.packet_flags     = res_q.packet_flags;
	assign parsed.remaining_length = res_q.remaining_length;
	assign parsed.packet_done      = res_q.packet_done;
	assign parsed.event_code       = res_q.event_code;
	assign parsed.return_code      = res_q.return_code;
	assign parsed.topic_length     = res_q.topic_length;
	assign parsed.publish_count    = res_q.publish_count;

`ifndef SYNTHESIS
	a_done_has_event: assert property (@(posedge clk) disable iff (!arst_n)
		parsed.valid |-> (parsed.packet_done == (parsed.event_code != mqttrx_pkg::EV_NONE)))
		else $error("packet_done and event_code disagree");

	a_error_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && ev_d == mqttrx_pkg::EV_PROTOCOL_ERROR)
		|=> (phase_q == mqttrx_pkg::PH_HEADER && accum_q == '0 && lcnt_q == '0))
		else $error("parser not restarted after length error");

	a_count_only_on_publish: assert property (@(posedge clk) disable iff (!arst_n)
		!(acc && ev_d == mqttrx_pkg::EV_PUBLISH) |=> $stable(pub_cnt_q))
		else $error("publish counter moved without a valid publish");
`endif

endmodule

`default_nettype wire
